// File: sv/spc_pkg.sv
// Shared types and constants of the servo position PID controller.
package spc_pkg;

  localparam int unsigned PotW    = 12;
  localparam int unsigned DegW    = 8;
  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned TolW    = 15;
  localparam int unsigned ErrW    = 16;
  localparam int unsigned IntegW  = 32;
  localparam int unsigned DutyW   = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 31;

  localparam logic [DegW-1:0]    DegMax     = 8'd239;
  localparam int unsigned        OutShift   = 8 + 5;
  localparam logic [DutyW-1:0]   SpeedMax   = 10'd1023;

  localparam logic [LimitW-1:0]  LimitReset = 31'd1073741824;
  localparam logic [TolW-1:0]    TolReset   = 15'd64;

  typedef enum logic {
    OP_SAMPLE   = 1'b0,
    OP_SETPOINT = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_INTEG_LIMIT = 3'd3,
    CFG_ERR_TOL     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic [LimitW-1:0]       integ_limit;
    logic [TolW-1:0]         err_tol;
  } cfg_t;

  typedef struct packed {
    logic [PotW-1:0]          setpoint;
    logic signed [IntegW-1:0] integ;
    logic signed [ErrW-1:0]   prev_err;
    logic                     seen;
  } state_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             direction;
    logic             brake;
    logic [DegW-1:0]  position_degree;
  } result_t;

endpackage

// File: sv/spc_datapath.sv
// Single-pass PID datapath: next controller state and the drive result for one item.
module spc_datapath (
  input  spc_pkg::op_e               op_i,
  input  logic [spc_pkg::PotW-1:0]   pot_reading_i,
  input  logic [spc_pkg::DegW-1:0]   target_degree_i,
  input  spc_pkg::cfg_t              cfg_i,
  input  spc_pkg::state_t            state_i,
  output spc_pkg::state_t            state_o,
  output spc_pkg::result_t           result_o
);
  import spc_pkg::*;

  logic [DegW-1:0]          deg_clamped;
  logic [PotW-1:0]          sp_from_deg;
  logic [PotW-1:0]          sp_eff;
  logic signed [PotW:0]     diff;
  logic signed [ErrW-1:0]   err;
  logic signed [31:0]       prod_p;
  logic signed [31:0]       prod_i;
  logic signed [ErrW:0]     diff_d;
  logic signed [32:0]       prod_d;
  logic signed [32:0]       acc_raw;
  logic signed [32:0]       lim_pos;
  logic signed [32:0]       lim_neg;
  logic signed [32:0]       acc_clamp;
  logic signed [ErrW:0]     err_ext;
  logic signed [ErrW:0]     tol_pos;
  logic                     in_band;
  logic signed [IntegW-1:0] acc_final;
  logic signed [34:0]       sum;
  logic signed [21:0]       speed_sh;
  logic signed [DutyW:0]    speed;
  logic [15:0]              pos_scaled;

  // Degrees to counts: deg*17 + deg/8, done with shifts.
  assign deg_clamped = (target_degree_i > DegMax) ? DegMax : target_degree_i;
  assign sp_from_deg = {deg_clamped, 4'b0} + {4'b0, deg_clamped}
                     + {7'b0, deg_clamped[DegW-1:3]};

  // The first sample adopts its own reading as setpoint.
  assign sp_eff = state_i.seen ? state_i.setpoint : pot_reading_i;
  assign diff   = $signed({1'b0, sp_eff}) - $signed({1'b0, pot_reading_i});
  assign err    = {diff, 3'b000};

  assign prod_p = err * cfg_i.gain_p;
  assign prod_i = err * cfg_i.gain_i;
  assign diff_d = {err[ErrW-1], err} - {state_i.prev_err[ErrW-1], state_i.prev_err};
  assign prod_d = diff_d * cfg_i.gain_d;

  // Integrator with anti-windup clamp and a dead band that empties it.
  assign acc_raw = {state_i.integ[IntegW-1], state_i.integ} + {prod_i[31], prod_i};
  assign lim_pos = $signed({2'b00, cfg_i.integ_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (acc_raw > lim_pos) begin
      acc_clamp = lim_pos;
    end else if (acc_raw < lim_neg) begin
      acc_clamp = lim_neg;
    end else begin
      acc_clamp = acc_raw;
    end
  end

  assign err_ext   = {err[ErrW-1], err};
  assign tol_pos   = $signed({2'b00, cfg_i.err_tol});
  assign in_band   = (err_ext > -tol_pos) && (err_ext < tol_pos);
  assign acc_final = in_band ? '0 : acc_clamp[IntegW-1:0];

  assign sum = {{3{prod_p[31]}}, prod_p} + {{3{acc_final[IntegW-1]}}, acc_final}
             + {{2{prod_d[32]}}, prod_d};
  // Arithmetic shift floors toward minus infinity.
  assign speed_sh = sum[34:OutShift];

  always_comb begin
    if (speed_sh > $signed({12'b0, SpeedMax})) begin
      speed = $signed({1'b0, SpeedMax});
    end else if (speed_sh < -$signed({12'b0, SpeedMax})) begin
      speed = -$signed({1'b0, SpeedMax});
    end else begin
      speed = speed_sh[DutyW:0];
    end
  end

  assign pos_scaled = {pot_reading_i, 4'b0} - {4'b0, pot_reading_i};

  always_comb begin
    state_o = state_i;
    if (op_i == OP_SETPOINT) begin
      state_o.setpoint = sp_from_deg;
      state_o.integ    = '0;
    end else begin
      state_o.setpoint = sp_eff;
      state_o.integ    = acc_final;
      state_o.prev_err = err;
      state_o.seen     = 1'b1;
    end
  end

  always_comb begin
    result_o.duty            = speed[DutyW] ? DutyW'(-speed) : speed[DutyW-1:0];
    result_o.direction       = !speed[DutyW] && (speed != '0);
    result_o.brake           = (speed == '0);
    result_o.position_degree = pos_scaled[15:8];
  end

endmodule

// File: sv/servo_pid_position_control.sv
// Top level of the servo position PID controller with integrator anti-windup.
//
// Items enter on the in channel: a sample item (op 0) carries a 12-bit pot
// reading and yields one result (duty, direction, brake, pot angle), a
// setpoint item (op 1) carries a target angle, clears the integrator and
// yields nothing. An accepted item is held in the input register; all
// of its arithmetic (three multiplies by the 16-bit gains, the clamped
// integrator update and the saturated P+I+D sum) is one combinational pass
// from there into the result register and the controller state, which are
// loaded as the item leaves the input register, and one item per cycle is
// sustained while the consumer keeps taking results. The integrator
// recurrence through that pass is what sets the clock. A stalled result holds
// a sample item in the input register, and the input waits until that result
// is taken; a setpoint item never waits. Configuration writes land at once and
// should only be issued while no items are in flight.
module servo_pid_position_control (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic [spc_pkg::PotW-1:0]           pot_reading_i,
  input  logic [spc_pkg::DegW-1:0]           target_degree_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [spc_pkg::DutyW-1:0]          duty_o,
  output logic                               direction_o,
  output logic                               brake_o,
  output logic [spc_pkg::DegW-1:0]           position_degree_o,
  input  logic                               cfg_we_i,
  input  logic [spc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [spc_pkg::CfgDatW-1:0]        cfg_wdata_i
);
  import spc_pkg::*;

  // Input register.
  logic             s1_valid_q, s1_valid_d;
  op_e              s1_op_q;
  logic [PotW-1:0]  s1_pot_q;
  logic [DegW-1:0]  s1_deg_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  result_t          result_q;
  result_t          result_d;

  state_t           state_q;
  state_t           state_d;
  cfg_t             cfg_q;

  logic             in_fire;
  logic             advance;

  // A setpoint item never needs the result register, so it moves on at once.
  assign advance    = s1_valid_q && ((s1_op_q == OP_SETPOINT) || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire || (s1_valid_q && !advance);
  assign out_valid_d = (advance && (s1_op_q == OP_SAMPLE)) || (out_valid_q && !out_ready_i);

  spc_datapath u_datapath (
    .op_i            (s1_op_q),
    .pot_reading_i   (s1_pot_q),
    .target_degree_i (s1_deg_q),
    .cfg_i           (cfg_q),
    .state_i         (state_q),
    .state_o         (state_d),
    .result_o        (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= op_e'(op_i);
      s1_pot_q <= pot_reading_i;
      s1_deg_q <= target_degree_i;
    end
    if (advance && (s1_op_q == OP_SAMPLE)) begin
      result_q <= result_d;
    end
  end

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= '0;
      cfg_q.gain_i      <= '0;
      cfg_q.gain_d      <= '0;
      cfg_q.integ_limit <= LimitReset;
      cfg_q.err_tol     <= TolReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_P:      cfg_q.gain_p      <= cfg_wdata_i[GainW-1:0];
        CFG_GAIN_I:      cfg_q.gain_i      <= cfg_wdata_i[GainW-1:0];
        CFG_GAIN_D:      cfg_q.gain_d      <= cfg_wdata_i[GainW-1:0];
        CFG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_wdata_i[LimitW-1:0];
        CFG_ERR_TOL:     cfg_q.err_tol     <= cfg_wdata_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign duty_o            = result_q.duty;
  assign direction_o       = result_q.direction;
  assign brake_o           = result_q.brake;
  assign position_degree_o = result_q.position_degree;

  // A braked result carries no drive at all.
  a_brake_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.brake |-> (result_q.duty == '0) && !result_q.direction)
    else $error("brake with nonzero drive");

  // A running drive always has a nonzero duty.
  a_drive_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_q.brake |-> (result_q.duty != '0))
    else $error("drive without duty");

  // A setpoint item leaving the input register must not create a result.
  a_setpoint_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (s1_op_q == OP_SETPOINT) && !out_valid_q |=> !out_valid_q)
    else $error("setpoint item produced a result");

  // The input side only stalls while the input register is occupied.
  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without cause");

endmodule

// File: tb/tb_servo_pid_position_control.sv
`timescale 1ns / 100ps
// Self-checking testbench for the servo position PID controller with anti-windup.
module tb_servo_pid_position_control;
  import spc_pkg::*;

  // The run is ended by the watchdog if it ever gets this far.
  localparam int CycleLimit     = 500000;
  // A result is registered in the result register once its item leaves the input register.
  localparam int Latency        = 1;
  localparam int DegScale       = 17;
  localparam int ErrScale       = 8;
  localparam int PosScale       = 15;
  localparam int PosShift       = 8;
  localparam int RandomPhases   = 7;
  localparam int ItemsPerPhase  = 100;
  localparam int MaxPrinted     = 40;
  localparam int unsigned LimitMax = 32'h7FFF_FFFF;
  localparam int unsigned TolMax   = 32'h0000_7FFF;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                op_i;
  logic [PotW-1:0]     pot_reading_i;
  logic [DegW-1:0]     target_degree_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [DutyW-1:0]    duty_o;
  logic                direction_o;
  logic                brake_o;
  logic [DegW-1:0]     position_degree_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDatW-1:0]  cfg_wdata_i;

  servo_pid_position_control DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .pot_reading_i     (pot_reading_i),
    .target_degree_i   (target_degree_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .duty_o            (duty_o),
    .direction_o       (direction_o),
    .brake_o           (brake_o),
    .position_degree_o (position_degree_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  // Shadow copy of the configuration registers, kept in step with every write.
  shortint     gain_p_sh;
  shortint     gain_i_sh;
  shortint     gain_d_sh;
  int unsigned limit_sh;
  int unsigned tol_sh;

  // Controller state as the predictor sees it.
  logic [15:0] model_setpoint;
  int          model_integ;
  int          model_prev_err;
  bit          model_seen;

  // Drive results still owed by the block, oldest first.
  result_t     drive_expected[$];

  // Idling knobs for the input side and the result side.
  bit          feed_stalls;
  bit          sink_stalls;

  int          mismatch_count;
  int          items_sent;
  int          setpoints_sent;
  int          results_checked;
  int          config_count;
  int          cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The watchdog counts every cycle and gives up once past the limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Watchdog expired after %0d cycles, %0d results still owed.",
               cycle_count, drive_expected.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Works out the drive result of one accepted item and updates the shadow
  // state. A setpoint item only moves the setpoint and empties the integrator.
  task automatic compute_drive(op_e op, logic [PotW-1:0] pot, logic [DegW-1:0] deg);
    logic [DegW-1:0] deg_clamped;
    int              err;
    longint          err_w;
    longint          acc;
    longint          lim;
    longint          tol;
    longint          total;
    longint          spd;
    result_t         res;
    if (op == OP_SETPOINT) begin
      deg_clamped = (deg > DegMax) ? DegMax : deg;
      model_setpoint = 16'(int'(deg_clamped) * DegScale + (int'(deg_clamped) >> 3));
      model_integ = 0;
      return;
    end
    // The very first sample takes its own reading as the setpoint, so it
    // always starts from a zero error.
    if (!model_seen) begin
      model_seen = 1'b1;
      model_setpoint = 16'(pot);
    end
    err   = (int'(model_setpoint) - int'(pot)) * ErrScale;
    err_w = longint'(err);
    lim   = longint'(limit_sh);
    tol   = longint'(tol_sh);
    // Integrator with anti-windup clamp, cleared inside the tolerance band.
    acc = longint'(model_integ) + err_w * longint'(gain_i_sh);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    if (err_w > -tol && err_w < tol) acc = 0;
    model_integ = int'(acc);
    // The full sum never wraps; the arithmetic shift rounds toward minus infinity.
    total = err_w * longint'(gain_p_sh) + acc
          + (err_w - longint'(model_prev_err)) * longint'(gain_d_sh);
    model_prev_err = err;
    spd = total >>> OutShift;
    if (spd > longint'(SpeedMax)) spd = longint'(SpeedMax);
    if (spd < -longint'(SpeedMax)) spd = -longint'(SpeedMax);
    res.duty            = DutyW'((spd < 0) ? -spd : spd);
    res.direction       = (spd > 0);
    res.brake           = (spd == 0);
    res.position_degree = DegW'((int'(pot) * PosScale) >> PosShift);
    drive_expected.push_back(res);
  endtask

  // Offers one item and waits for it to be taken. Valid is only lowered when
  // a gap is wanted, so back-to-back items keep it high without a glitch.
  task automatic send_item(op_e op, logic [PotW-1:0] pot, logic [DegW-1:0] deg);
    int gap;
    gap = feed_stalls ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    pot_reading_i   <= pot;
    target_degree_i <= deg;
    do @(posedge clk_i); while (!in_ready_o);
    compute_drive(op, pot, deg);
    items_sent++;
    if (op == OP_SETPOINT) setpoints_sent++;
  endtask

  // Lets every owed result come out, then waits out any setpoint item that
  // may still sit in the pipeline, since that one leaves no trace.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDatW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_GAIN_P:      gain_p_sh = shortint'(data[GainW-1:0]);
      CFG_GAIN_I:      gain_i_sh = shortint'(data[GainW-1:0]);
      CFG_GAIN_D:      gain_d_sh = shortint'(data[GainW-1:0]);
      CFG_INTEG_LIMIT: limit_sh  = 32'(data[LimitW-1:0]);
      CFG_ERR_TOL:     tol_sh    = 32'(data[TolW-1:0]);
      default: ;
    endcase
  endtask

  // Rewrites all five registers once the block is idle. The unused upper bits
  // of the narrow registers carry noise that the block has to drop.
  task automatic program_gains(shortint p, shortint i, shortint d,
                               int unsigned lim, int unsigned tol);
    drain_pipeline();
    write_reg(CFG_GAIN_P, {15'($urandom()), p});
    write_reg(CFG_GAIN_I, {15'($urandom()), i});
    write_reg(CFG_GAIN_D, {15'($urandom()), d});
    write_reg(CFG_INTEG_LIMIT, CfgDatW'(lim));
    write_reg(CFG_ERR_TOL, {16'($urandom()), 15'(tol)});
    cfg_we_i <= 1'b0;
    config_count++;
  endtask

  function automatic shortint pick_gain();
    case ($urandom_range(0, 4))
      0:       return -16'sd32768;
      1:       return 16'sh7FFF;
      2:       return 16'sd0;
      3:       return shortint'($urandom_range(0, 4096) - 2048);
      default: return shortint'($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_limit();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return LimitMax;
      2:       return 32'(LimitReset);
      3:       return $urandom_range(0, 1 << 24);
      default: return $urandom() & LimitMax;
    endcase
  endfunction

  function automatic int unsigned pick_tol();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return TolMax;
      2:       return $urandom_range(0, 512);
      default: return $urandom_range(0, TolMax);
    endcase
  endfunction

  // Under reset values all gains are zero, so every sample brakes. A setpoint
  // sent ahead of the first sample is overridden by that sample's reading.
  task automatic test_reset_defaults();
    send_item(OP_SETPOINT, 12'd0, 8'd100);
    send_item(OP_SAMPLE, 12'd2000, 8'd0);
    send_item(OP_SAMPLE, 12'd0, 8'hFF);
    send_item(OP_SAMPLE, 12'hFFF, 8'd0);
  endtask

  // Degrees above the top of the range clamp to it; zero and the edges of the
  // reading range give a clean brake and a negative drive direction.
  task automatic test_setpoint_clamp();
    program_gains(16'sh7FFF, 16'sd0, 16'sd0, 32'(LimitReset), 0);
    send_item(OP_SETPOINT, 12'hABC, 8'd255);
    send_item(OP_SAMPLE, 12'd4092, 8'd0);
    send_item(OP_SAMPLE, 12'hFFF, 8'd0);
    send_item(OP_SETPOINT, 12'd0, 8'd240);
    send_item(OP_SAMPLE, 12'd4092, 8'd0);
    send_item(OP_SETPOINT, 12'hFFF, 8'd0);
    send_item(OP_SAMPLE, 12'd0, 8'd0);
    send_item(OP_SAMPLE, 12'd1, 8'd0);
  endtask

  // A small limit makes the integrator clamp; a near-zero error clears it, and
  // so does a setpoint item, which leaves the previous error alone.
  task automatic test_integrator_windup();
    program_gains(16'sd0, 16'sd20000, 16'sd0, 32'd1 << 20, 64);
    send_item(OP_SETPOINT, 12'd0, 8'd120);
    send_item(OP_SAMPLE, 12'd1900, 8'd0);
    send_item(OP_SAMPLE, 12'd1950, 8'd0);
    send_item(OP_SAMPLE, 12'd2052, 8'd0);
    send_item(OP_SAMPLE, 12'd1900, 8'd0);
    send_item(OP_SETPOINT, 12'd0, 8'd120);
  endtask

  // Full-scale gains of both signs with full-scale error swings: the sum goes
  // far past the output range and must saturate without wrapping.
  task automatic test_extreme_gains();
    program_gains(16'sh7FFF, -16'sd32768, -16'sd32768, LimitMax, 0);
    send_item(OP_SETPOINT, 12'd0, 8'd0);
    send_item(OP_SAMPLE, 12'hFFF, 8'd0);
    send_item(OP_SAMPLE, 12'd0, 8'd0);
    send_item(OP_SAMPLE, 12'hFFF, 8'd0);
    program_gains(-16'sd32768, 16'sh7FFF, 16'sh7FFF, 0, TolMax);
    send_item(OP_SAMPLE, 12'd0, 8'd0);
    send_item(OP_SAMPLE, 12'hFFF, 8'd0);
    send_item(OP_SAMPLE, 12'd2048, 8'd0);
  endtask

  // Most samples sit near the current setpoint so that the integrator and the
  // tolerance band get exercised; the rest are spread wide or at the edges.
  task automatic send_random_item();
    logic [PotW-1:0] pot;
    logic [DegW-1:0] deg;
    int              spread;
    int              base;
    int              sel;
    deg = ($urandom_range(0, 9) == 0) ? DegW'($urandom_range(240, 255)) : DegW'($urandom());
    pot = PotW'($urandom());
    if ($urandom_range(0, 99) < 8) begin
      send_item(OP_SETPOINT, pot, deg);
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        case ($urandom_range(0, 2))
          0:       spread = 4;
          1:       spread = 64;
          default: spread = 600;
        endcase
        base = int'(model_setpoint) + int'($urandom_range(0, 2 * spread)) - spread;
        if (base < 0) base = 0;
        if (base > 4095) base = 4095;
        pot = PotW'(base);
      end else if (sel >= 85) begin
        pot = $urandom_range(0, 1) ? '1 : '0;
      end
      send_item(OP_SAMPLE, pot, deg);
    end
  endtask

  // Several register settings, the first two at the extremes, each with its own
  // mix of idling; one phase runs with both sides flat out.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0)
        program_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, LimitMax, 0);
      else if (phase == 1)
        program_gains(-16'sd32768, -16'sd32768, -16'sd32768, 0, TolMax);
      else
        program_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_tol());
      feed_stalls = (phase != 2) && ($urandom_range(0, 3) != 0);
      sink_stalls = (phase != 2) && ($urandom_range(0, 3) != 0);
      repeat (ItemsPerPhase) send_random_item();
    end
  endtask

  // The result side takes runs of results and stalls in between when asked to.
  initial begin : result_sink
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (sink_stalls) begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Every result taken is held against the oldest owed result, field by field.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_expected.size() == 0) begin
        report_mismatch($sformatf("result duty %0d pos %0d with nothing owed",
                                  duty_o, position_degree_o));
      end else begin
        want = drive_expected.pop_front();
        results_checked++;
        if (duty_o !== want.duty)
          report_mismatch($sformatf("duty %0d, expected %0d", duty_o, want.duty));
        if (direction_o !== want.direction)
          report_mismatch($sformatf("direction %0b, expected %0b",
                                    direction_o, want.direction));
        if (brake_o !== want.brake)
          report_mismatch($sformatf("brake %0b, expected %0b", brake_o, want.brake));
        if (position_degree_o !== want.position_degree)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    position_degree_o, want.position_degree));
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    op_i            <= OP_SAMPLE;
    pot_reading_i   <= '0;
    target_degree_i <= '0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= CFG_GAIN_P;
    cfg_wdata_i     <= '0;
    mismatch_count  = 0;
    items_sent      = 0;
    setpoints_sent  = 0;
    results_checked = 0;
    config_count    = 0;
    feed_stalls     = 1'b1;
    sink_stalls     = 1'b1;
    // Shadow registers and state start at their reset values.
    gain_p_sh       = 0;
    gain_i_sh       = 0;
    gain_d_sh       = 0;
    limit_sh        = 32'(LimitReset);
    tol_sh          = 32'(TolReset);
    model_setpoint  = '0;
    model_integ     = 0;
    model_prev_err  = 0;
    model_seen      = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_setpoint_clamp();
    test_integrator_windup();
    test_extreme_gains();
    test_random_traffic();

    drain_pipeline();
    $display("Sent %0d items (%0d of them setpoints) and checked %0d drive results",
             items_sent, setpoints_sent, results_checked);
    $display("across %0d register settings in %0d cycles.", config_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/spc_pkg.sv
sv/spc_datapath.sv
sv/servo_pid_position_control.sv
tb/tb_servo_pid_position_control.sv
